// ===== rtl/lkv_pkg.sv =====
// lkv_pkg: sizes, constants and the broadcast/status word types of the
// lru key/value cache. No dependencies; used by lkv_cell and the top level.
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int KEY_W = 32;
	localparam int VAL_W = 8;
	localparam int CAP_W = 4;
	localparam int OCC_W = 4;
	localparam int AGE_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

	// lookup side of the broadcast, independent of cell status
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             evict_en;
		logic [AGE_W-1:0] victim_age;
	} lkv_look_t;

	// update side of the broadcast, built from the gathered cell status
	typedef struct packed {
		logic             touch_en;
		logic             insert_en;
		logic             write_value;
		logic [AGE_W-1:0] touch_age;
		logic [VAL_W-1:0] value;
	} lkv_upd_t;

	// what each cell reports back
	typedef struct packed {
		logic             match;
		logic             valid;
		logic [AGE_W-1:0] age;
		logic [VAL_W-1:0] value;
	} lkv_stat_t;

endpackage
`default_nettype wire

// ===== rtl/lkv_cell.sv =====
// lkv_cell: one entry of the cache row (key, byte, valid, age) with its local
// match, retire and free-slot claim logic. Depends on lkv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lkv_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lkv_pkg::lkv_look_t look,
	input  wire lkv_pkg::lkv_upd_t  upd,
	input  wire logic              claim_in,
	output logic                   claim_out,
	output lkv_pkg::lkv_stat_t     stat
);

	logic [lkv_pkg::KEY_W-1:0] key_q;
	logic [lkv_pkg::VAL_W-1:0] value_q;
	logic                      valid_q;
	logic [lkv_pkg::AGE_W-1:0] age_q;

	logic retiring;
	logic keep;
	logic match;
	logic avail;
	logic chosen;

	// oldest entry leaves when the put runs on a full store
	assign retiring  = look.evict_en & valid_q & (age_q == look.victim_age);
	assign keep      = valid_q & ~retiring;
	assign match     = keep & (key_q == look.key);
	assign avail     = ~keep;
	assign chosen    = avail & ~claim_in;
	assign claim_out = claim_in | avail;

	assign stat.match = match;
	assign stat.valid = valid_q;
	assign stat.age   = age_q;
	assign stat.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else begin
			if (retiring) begin
				valid_q <= 1'b0;
				age_q   <= '0;
			end
			if (upd.touch_en) begin
				if (match) begin
					age_q <= '0;
				end else if (keep && (age_q < upd.touch_age)) begin
					age_q <= age_q + lkv_pkg::AGE_W'(1);
				end
			end
			if (upd.insert_en) begin
				if (chosen) begin
					valid_q <= 1'b1;
					age_q   <= '0;
				end else if (keep) begin
					age_q <= age_q + lkv_pkg::AGE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.insert_en && chosen) begin
			key_q   <= look.key;
			value_q <= upd.value;
		end else if (upd.touch_en && upd.write_value && match) begin
			value_q <= upd.value;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lru_key_value_cache_unit.sv =====
// lru_key_value_cache_unit: top level of the fully associative lru key/value
// cache; a row of lkv_cell entries plus occupancy and output register.
// Depends on lkv_pkg and lkv_cell.
`timescale 1ns / 1ps
`default_nettype none
// usage
//  - input channel (in_valid/in_ready): one word is mode, key, value_in.
//    mode 0 is a get, mode 1 a put. accepted when in_valid and in_ready.
//  - output channel (out_valid/out_ready): one word per input word, carrying
//    hit, value_out, evicted and occupancy after the operation.
//  - config channel (cfg_valid/cfg_ready/cfg_data): writes capacity; cfg_ready
//    is always high. write it only while no word is in flight.
//  - out_valid rises in the cycle after acceptance; throughput is one word per
//    cycle while out_ready stays high. the whole lookup, retire and age update
//    happen in the cycle of acceptance in the cell row, limited by the 32-bit
//    key compare and the free-slot claim chain that runs through every cell.
//  - the result sits in one output register; a new word is taken in the same
//    cycle the held word leaves, so a stalled receiver stalls the input side
//    with in_ready low and nothing is lost.
//  - reset clears all valid bits, ages and occupancy, sets capacity to 8 and
//    empties the output register. no clearing pass is needed.
//  - the least recent entry is the valid one whose age equals occupancy-1.
module lru_key_value_cache_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             mode,
	input  wire logic signed [lkv_pkg::KEY_W-1:0] key,
	input  wire logic        [lkv_pkg::VAL_W-1:0] value_in,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  hit,
	output logic             [lkv_pkg::VAL_W-1:0] value_out,
	output logic                                  evicted,
	output logic             [lkv_pkg::OCC_W-1:0] occupancy,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic        [lkv_pkg::CAP_W-1:0] cfg_data
);

	localparam int N = lkv_pkg::MAX_ENTRIES;

	// control registers
	logic [lkv_pkg::CAP_W-1:0] capacity_q;
	logic [lkv_pkg::CNT_W-1:0] count_q;
	logic                      out_valid_q;

	// output word register
	logic                      hit_q;
	logic [lkv_pkg::VAL_W-1:0] value_q;
	logic                      evicted_q;
	logic [lkv_pkg::OCC_W-1:0] occ_q;

	logic accept;

	// capacity clamp and full test
	logic [lkv_pkg::CMP_W-1:0] cap_ext;
	logic [lkv_pkg::CMP_W-1:0] cap_eff;
	logic [lkv_pkg::CMP_W-1:0] cnt_ext;
	logic                      full;
	logic                      evict_en;
	logic [lkv_pkg::CNT_W-1:0] count_dec;

	// cell row wiring
	lkv_pkg::lkv_look_t look;
	lkv_pkg::lkv_upd_t  upd;
	lkv_pkg::lkv_stat_t stat [N];
	logic [N:0]         claim;
	logic [N-1:0]       match_vec;
	logic [N-1:0]       valid_vec;

	// gathered status
	logic                      any_match;
	logic [lkv_pkg::AGE_W-1:0] match_age;
	logic [lkv_pkg::VAL_W-1:0] match_value;
	logic                      insert_en;

	logic [lkv_pkg::CNT_W-1:0]               count_next;
	logic [lkv_pkg::CNT_W+lkv_pkg::OCC_W-1:0] occ_wide;

	assign cfg_ready = 1'b1;
	assign in_ready  = ~out_valid_q | out_ready;
	assign accept    = in_valid & in_ready;

	// capacity above the row size acts as the row size
	assign cap_ext  = lkv_pkg::CMP_W'(capacity_q);
	assign cnt_ext  = lkv_pkg::CMP_W'(count_q);
	assign cap_eff  = (cap_ext > lkv_pkg::CMP_W'(N)) ? lkv_pkg::CMP_W'(N) : cap_ext;
	assign full     = cnt_ext >= cap_eff;
	// an empty store has nothing to retire, even at capacity zero
	assign evict_en = accept & mode & full & (count_q != '0);

	// valid ages are always 0..count-1, so the oldest is at count-1
	assign count_dec       = count_q - lkv_pkg::CNT_W'(1);
	assign look.key        = key;
	assign look.evict_en   = evict_en;
	assign look.victim_age = count_dec[lkv_pkg::AGE_W-1:0];

	// free-slot claim runs from cell 0 upward
	assign claim[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		lkv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.look     (look),
			.upd      (upd),
			.claim_in (claim[i]),
			.claim_out(claim[i+1]),
			.stat     (stat[i])
		);
		assign match_vec[i] = stat[i].match;
		assign valid_vec[i] = stat[i].valid;
	end

	// stored keys are distinct, so at most one cell matches
	always_comb begin
		match_age   = '0;
		match_value = '0;
		for (int i = 0; i < N; i++) begin
			if (stat[i].match) begin
				match_age   = match_age | stat[i].age;
				match_value = match_value | stat[i].value;
			end
		end
	end

	assign any_match = |match_vec;
	assign insert_en = accept & mode & ~any_match;

	assign upd.touch_en    = accept & any_match;
	assign upd.insert_en   = insert_en;
	assign upd.write_value = mode;
	assign upd.touch_age   = match_age;
	assign upd.value       = value_in;

	assign count_next = count_q - lkv_pkg::CNT_W'(evict_en) + lkv_pkg::CNT_W'(insert_en);
	// occupancy reported in four bits, masked when the row is wider
	assign occ_wide   = {{lkv_pkg::OCC_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= lkv_pkg::CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word, loaded on acceptance only
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q     <= ~mode & any_match;
			value_q   <= (~mode & any_match) ? match_value : '0;
			evicted_q <= evict_en;
			occ_q     <= occ_wide[lkv_pkg::OCC_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign value_out = value_q;
	assign evicted   = evicted_q;
	assign occupancy = occ_q;

	// at most one live entry holds any key
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell matched the key");

	// occupancy tracks the valid bits of the row
	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == count_q)
		else $error("occupancy differs from valid entry count");

	// an insert always finds a free cell in the claim chain
	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		insert_en |-> claim[N])
		else $error("insert without a free cell");

	// occupancy never exceeds the row size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		lkv_pkg::CMP_W'(count_q) <= lkv_pkg::CMP_W'(N))
		else $error("occupancy above row size");

	// an eviction is only reported for a put that is not a hit result
	a_evict_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		accept && evict_en |=> out_valid_q && evicted_q && !hit_q)
		else $error("eviction result inconsistent");

endmodule
`default_nettype wire

// ===== bench/tb_lru_key_value_cache_unit.sv =====
// tb_lru_key_value_cache_unit: self-checking bench for the lru key/value cache,
// directed table then random get/put traffic under varied capacity and idling.
// Depends on lkv_pkg and lru_key_value_cache_unit.
`timescale 1ns / 1ps
module tb_lru_key_value_cache_unit;
	import lkv_pkg::*;

	typedef enum bit {OP_GET = 1'b0, OP_PUT = 1'b1} op_e;
	typedef enum bit {ROW_WORD, ROW_CAP} row_kind_e;

	// one result word as the block reports it
	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value;
		logic             evicted;
		logic [OCC_W-1:0] occupancy;
	} cache_result_t;

	// directed row: either a word to send or a capacity write
	typedef struct {
		row_kind_e        kind;
		op_e              op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [CAP_W-1:0] cap;
		bit               typed;
		cache_result_t    want;
	} dir_row_t;

	// result typed into the table, handed from the sender to the monitor
	typedef struct {
		bit            typed;
		cache_result_t want;
	} fixed_result_t;

	localparam cache_result_t NO_RESULT = '0;
	localparam int N_DIR = 27;
	localparam int POOL_N = 12;
	localparam int SEG_WORDS = 110;
	localparam int LONG_HOLD = 80;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    mode;
	logic signed [KEY_W-1:0] key;
	logic        [VAL_W-1:0] value_in;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    hit;
	logic        [VAL_W-1:0] value_out;
	logic                    evicted;
	logic        [OCC_W-1:0] occupancy;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic        [CAP_W-1:0] cfg_data;

	lru_key_value_cache_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.key       (key),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.value_out (value_out),
		.evicted   (evicted),
		.occupancy (occupancy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow copy of the cache contents and the capacity register
	logic [KEY_W-1:0] slot_key  [MAX_ENTRIES];
	logic [VAL_W-1:0] slot_byte [MAX_ENTRIES];
	bit               slot_live [MAX_ENTRIES];
	int               slot_age  [MAX_ENTRIES];
	int               live_count = 0;
	logic [CAP_W-1:0] cap_model = CAP_RESET;

	cache_result_t pending_results [$];
	fixed_result_t fixed_results [$];

	int n_errors = 0;
	int n_results = 0;
	int n_gets = 0;
	int n_hits = 0;
	int n_puts = 0;
	int n_evicts = 0;
	int n_cfg = 0;

	// idling knobs and the long receiver hold-off request
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	logic [KEY_W-1:0] key_pool [POOL_N];
	dir_row_t dir_rows [0:N_DIR-1];
	int cap_plan [9];

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on result %0d: %s is %0h, expected %0h", n_results, what, got, want);
		n_errors++;
	endtask

	function automatic int find_slot(logic [KEY_W-1:0] k);
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (slot_live[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	// make slot s the most recent; live entries younger than it age by one
	function automatic void promote(int s);
		int a;
		a = slot_age[s];
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (slot_live[i] && i != s && slot_age[i] < a)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	// apply one get or put to the shadow cache and return the result word
	function automatic cache_result_t lru_access(op_e op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		cache_result_t r;
		int s;
		int victim;
		int limit;
		r = NO_RESULT;
		s = find_slot(k);
		if (op == OP_GET) begin
			if (s >= 0) begin
				r.hit = 1'b1;
				r.value = slot_byte[s];
				promote(s);
			end
		end else begin
			limit = (int'(cap_model) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_model);
			// at capacity the oldest goes first, even if the key is stored
			if (live_count >= limit) begin
				victim = -1;
				for (int i = 0; i < MAX_ENTRIES; i++)
					if (slot_live[i] && (victim < 0 || slot_age[i] > slot_age[victim]))
						victim = i;
				if (victim >= 0) begin
					slot_live[victim] = 1'b0;
					slot_age[victim] = 0;
					live_count--;
					r.evicted = 1'b1;
				end
				s = find_slot(k);
			end
			if (s >= 0) begin
				slot_byte[s] = v;
				promote(s);
			end else begin
				for (int i = MAX_ENTRIES - 1; i >= 0; i--)
					if (!slot_live[i])
						s = i;
				for (int i = 0; i < MAX_ENTRIES; i++)
					if (slot_live[i])
						slot_age[i]++;
				slot_key[s] = k;
				slot_byte[s] = v;
				slot_live[s] = 1'b1;
				slot_age[s] = 0;
				live_count++;
			end
		end
		r.occupancy = OCC_W'(live_count);
		return r;
	endfunction

	// monitor: check leaving words first, then predict for the word taken this edge
	always @(posedge clk) begin
		cache_result_t got;
		cache_result_t want;
		fixed_result_t fx;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				got = '{hit, value_out, evicted, occupancy};
				if (pending_results.size() == 0) begin
					report_mismatch("result word with nothing pending", 32'(got), 0);
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					if (got.hit !== want.hit)
						report_mismatch("hit", 32'(got.hit), 32'(want.hit));
					if (got.value !== want.value)
						report_mismatch("value_out", 32'(got.value), 32'(want.value));
					if (got.evicted !== want.evicted)
						report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
					if (got.occupancy !== want.occupancy)
						report_mismatch("occupancy", 32'(got.occupancy), 32'(want.occupancy));
				end
			end
			if (in_valid && in_ready) begin
				want = lru_access(op_e'(mode), key, value_in);
				if (mode == OP_GET) begin
					n_gets++;
					n_hits += want.hit;
				end else begin
					n_puts++;
					n_evicts += want.evicted;
				end
				fx = fixed_results[0];
				fixed_results.delete(0);
				pending_results.push_back(fx.typed ? fx.want : want);
			end
			if (cfg_valid && cfg_ready) begin
				cap_model = cfg_data;
				n_cfg++;
			end
		end
	end

	// receiver: random stalls, or a long counted hold-off when requested
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_word(op_e op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
			bit typed, cache_result_t want);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		fixed_results.push_back('{typed, want});
		in_valid = 1'b1;
		mode = op;
		key = k;
		value_in = v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// capacity is only written with the block idle
	task automatic write_capacity(logic [CAP_W-1:0] c);
		in_valid = 1'b0;
		drain_results();
		cfg_valid = 1'b1;
		cfg_data = c;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		// mostly a small key set so gets hit and puts update
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom();
	endfunction

	initial begin
		op_e op;
		in_valid = 1'b0;
		mode = 1'b0;
		key = '0;
		value_in = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			slot_key[i] = '0;
			slot_byte[i] = '0;
			slot_live[i] = 1'b0;
			slot_age[i] = 0;
		end

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_N; i++)
			key_pool[i] = $urandom();

		// extremes first, then lowering below occupancy and the zero setting
		cap_plan = '{8, 1, 15, 3, 0, 12, 0, 0, 7};
		cap_plan[6] = $urandom_range(0, 15);
		cap_plan[7] = $urandom_range(0, 15);

		// kind, op, key, byte, capacity, typed, {hit, value_out, evicted, occupancy}
		dir_rows = '{
			// get on an empty store
			'{ROW_WORD, OP_GET, 32'h0000_0000, 8'h00, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd0}},
			// capacity zero: first put on an empty store retires nothing
			'{ROW_CAP,  OP_GET, 32'h0000_0000, 8'h00, 4'd0, 1'b0, NO_RESULT},
			'{ROW_WORD, OP_PUT, 32'h8000_0000, 8'hFF, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd1}},
			// every later put retires, occupancy stays one
			'{ROW_WORD, OP_PUT, 32'h7FFF_FFFF, 8'h00, 4'd0, 1'b1, {1'b0, 8'h00, 1'b1, 4'd1}},
			'{ROW_WORD, OP_GET, 32'h8000_0000, 8'h00, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd1}},
			'{ROW_WORD, OP_GET, 32'h7FFF_FFFF, 8'h00, 4'd0, 1'b1, {1'b1, 8'h00, 1'b0, 4'd1}},
			// full store whose oldest entry holds the key: retired, inserted afresh
			'{ROW_CAP,  OP_GET, 32'h0000_0000, 8'h00, 4'd1, 1'b0, NO_RESULT},
			'{ROW_WORD, OP_PUT, 32'h7FFF_FFFF, 8'h3C, 4'd0, 1'b1, {1'b0, 8'h00, 1'b1, 4'd1}},
			'{ROW_WORD, OP_GET, 32'h7FFF_FFFF, 8'h00, 4'd0, 1'b1, {1'b1, 8'h3C, 1'b0, 4'd1}},
			// capacity above the entry count acts as full size
			'{ROW_CAP,  OP_GET, 32'h0000_0000, 8'h00, 4'd15, 1'b0, NO_RESULT},
			'{ROW_WORD, OP_PUT, 32'hFFFF_FFFF, 8'hA5, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd2}},
			'{ROW_WORD, OP_PUT, 32'h0000_0000, 8'h01, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd3}},
			'{ROW_WORD, OP_PUT, 32'h0000_0001, 8'h11, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd4}},
			'{ROW_WORD, OP_PUT, 32'h0000_0002, 8'h22, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd5}},
			'{ROW_WORD, OP_PUT, 32'h0000_0003, 8'h33, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd6}},
			'{ROW_WORD, OP_PUT, 32'h0000_0004, 8'h44, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd7}},
			'{ROW_WORD, OP_PUT, 32'h0000_0005, 8'h55, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd8}},
			'{ROW_WORD, OP_GET, 32'h7FFF_FFFF, 8'h00, 4'd0, 1'b1, {1'b1, 8'h3C, 1'b0, 4'd8}},
			// update of a stored key on a full store still retires the oldest
			'{ROW_WORD, OP_PUT, 32'h0000_0000, 8'h77, 4'd0, 1'b1, {1'b0, 8'h00, 1'b1, 4'd7}},
			'{ROW_WORD, OP_GET, 32'hFFFF_FFFF, 8'h00, 4'd0, 1'b1, {1'b0, 8'h00, 1'b0, 4'd7}},
			'{ROW_WORD, OP_GET, 32'h0000_0000, 8'h00, 4'd0, 1'b1, {1'b1, 8'h77, 1'b0, 4'd7}},
			// capacity lowered below occupancy: one retire per put
			'{ROW_CAP,  OP_GET, 32'h0000_0000, 8'h00, 4'd3, 1'b0, NO_RESULT},
			'{ROW_WORD, OP_PUT, 32'h1234_5678, 8'hC3, 4'd0, 1'b1, {1'b0, 8'h00, 1'b1, 4'd7}},
			'{ROW_WORD, OP_PUT, 32'h0BAD_F00D, 8'h96, 4'd0, 1'b0, NO_RESULT},
			'{ROW_WORD, OP_GET, 32'h1234_5678, 8'h00, 4'd0, 1'b0, NO_RESULT},
			'{ROW_WORD, OP_GET, 32'h0000_0002, 8'h00, 4'd0, 1'b0, NO_RESULT},
			'{ROW_CAP,  OP_GET, 32'h0000_0000, 8'h00, 4'd8, 1'b0, NO_RESULT}
		};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_idle_pct = 8;
		rx_idle_pct = 50;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CAP)
				write_capacity(dir_rows[r].cap);
			else
				offer_word(dir_rows[r].op, dir_rows[r].key, dir_rows[r].value,
					dir_rows[r].typed, dir_rows[r].want);
		end

		// three idling phases, each split into capacity segments
		for (int p = 0; p < 3; p++) begin
			tx_idle_pct = (p == 0) ? 8 : (p == 1) ? 50 : 0;
			rx_idle_pct = (p == 0) ? 50 : (p == 1) ? 8 : 0;
			for (int s = 0; s < 3; s++) begin
				write_capacity(CAP_W'(cap_plan[p * 3 + s]));
				for (int n = 0; n < SEG_WORDS; n++) begin
					// receiver holds off while words keep coming, so input stalls
					if (p == 0 && s == 0 && n == 20)
						hold_req++;
					// sender pauses until the pipe is empty
					if (p == 1 && s == 1 && n == 50) begin
						in_valid = 1'b0;
						drain_results();
					end
					op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
					offer_word(op, pick_key(), 8'($urandom_range(0, 255)), 1'b0, NO_RESULT);
				end
			end
		end

		in_valid = 1'b0;
		drain_results();
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never arrived", pending_results.size(), 0);

		$display("covered %0d gets (%0d hits) and %0d puts (%0d evictions)",
			n_gets, n_hits, n_puts, n_evicts);
		$display("over %0d capacity writes, with stalls on both sides; %0d mismatches",
			n_cfg, n_errors);
		if (n_errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("timeout waiting on the block");
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lkv_pkg.sv
rtl/lkv_cell.sv
rtl/lru_key_value_cache_unit.sv
bench/tb_lru_key_value_cache_unit.sv
